/* sv/assert_macros.svh */
// Assertion macros used by the heart-rate averager controller.
// Each macro clocks on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Asserts that a property holds at every rising clock edge outside reset.
`define ASSERT_CLKRST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Asserts that a condition is never true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

/* sv/hrbi_pkg.sv */
// Shared types, widths and constants of the heart-rate beat interval averager.
// Used by every module of the block; depends on nothing.
package hrbi_pkg;

	// Field and register widths.
	localparam int SAMPLE_W = 12;
	localparam int LEVEL_W  = 12;
	localparam int NUM_W    = 16;
	localparam int LIMIT_W  = 15;
	localparam int CNT_W    = 16;
	localparam int RATE_W   = 15;
	localparam int BLINK_W  = 11;

	// Rate history ring.
	localparam int HIST_DEPTH = 8;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);
	localparam int SUM_W      = RATE_W + HIST_AW;

	// Shared iterative divider.
	localparam int DIV_W  = 16;
	localparam int DIV_CW = $clog2(DIV_W);

	// APB port.
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	// Register reset values.
	localparam logic [LEVEL_W-1:0] UPPER_RST = 12'd2685;
	localparam logic [LEVEL_W-1:0] LOWER_RST = 12'd1590;
	localparam logic [NUM_W-1:0]   NUM_RST   = 16'd30000;
	localparam logic [LIMIT_W-1:0] ALARM_RST = 15'd130;
	localparam logic [LIMIT_W-1:0] SLOW_RST  = 15'd60;

	// Arithmetic limits.
	localparam logic [CNT_W-1:0]   COUNT_MAX     = 16'hFFFF;
	localparam logic [RATE_W-1:0]  RATE_MAX      = 15'h7FFF;
	localparam logic [BLINK_W-1:0] BLINK_SLOW    = 11'd1999;
	localparam logic [BLINK_W-1:0] BLINK_ALARM   = 11'd10;
	localparam logic [DIV_W-1:0]   MS_PER_MINUTE = 16'd60000;

	// Register indexes on the configuration port.
	typedef enum logic [2:0] {
		REG_UPPER = 3'd0,
		REG_LOWER = 3'd1,
		REG_NUM   = 3'd2,
		REG_ALARM = 3'd3,
		REG_SLOW  = 3'd4
	} reg_idx_t;

	// Hysteresis detector phases.
	typedef enum logic [1:0] {
		PH_WAIT_RISE = 2'd0,
		PH_WAIT_FALL = 2'd1,
		PH_CNT_RISE  = 2'd2,
		PH_CNT_FALL  = 2'd3
	} phase_t;

	// Configuration register set.
	typedef struct packed {
		logic [LEVEL_W-1:0] upper_level;
		logic [LEVEL_W-1:0] lower_level;
		logic [NUM_W-1:0]   rate_numerator;
		logic [LIMIT_W-1:0] alarm_limit;
		logic [LIMIT_W-1:0] slow_limit;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic rate_start;
		logic hist_update;
		logic class_eval;
		logic blink_start;
		logic blink_capture;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic period_done;
		logic fast_path;
		logic div_done;
		logic div_busy;
		logic out_free;
	} status_t;

endpackage

/* sv/heart_rate_beat_interval_averager.sv */
// Heart-rate beat interval averager, top level: registers, controller, datapath.
// A sample that does not end a beat period gives no item, and intake stays open.
// A sample that ends a period gives its item after the rate division, ring update and
// classification: directly on the fast path, or after a blink division on the 16-step shared divider.
// Throughput: one sample per cycle between beats; a beat holds intake until its result is emitted.
// Reset (arst_n low) restores register defaults and clears phase, count and rate ring.
module heart_rate_beat_interval_averager import hrbi_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [SAMPLE_W-1:0] sample,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [RATE_W-1:0]   average_rate,
	output logic [BLINK_W-1:0]  blink_period,
	output logic                alarm
);

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	hrbi_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	hrbi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	hrbi_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.status       (status),
		.sample       (sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.average_rate (average_rate),
		.blink_period (blink_period),
		.alarm        (alarm)
	);

endmodule

/* sv/hrbi_regs.sv */
// Configuration registers of the heart-rate averager behind an APB-style port.
// Depends on hrbi_pkg for the register set type, indexes and reset values.
module hrbi_regs import hrbi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.upper_level    <= UPPER_RST;
			cfg_q.lower_level    <= LOWER_RST;
			cfg_q.rate_numerator <= NUM_RST;
			cfg_q.alarm_limit    <= ALARM_RST;
			cfg_q.slow_limit     <= SLOW_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_UPPER: cfg_q.upper_level    <= pwdata[LEVEL_W-1:0];
				REG_LOWER: cfg_q.lower_level    <= pwdata[LEVEL_W-1:0];
				REG_NUM:   cfg_q.rate_numerator <= pwdata[NUM_W-1:0];
				REG_ALARM: cfg_q.alarm_limit    <= pwdata[LIMIT_W-1:0];
				REG_SLOW:  cfg_q.slow_limit     <= pwdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Read data follows the addressed register.
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_UPPER: prdata = PDATA_W'(cfg_q.upper_level);
			REG_LOWER: prdata = PDATA_W'(cfg_q.lower_level);
			REG_NUM:   prdata = PDATA_W'(cfg_q.rate_numerator);
			REG_ALARM: prdata = PDATA_W'(cfg_q.alarm_limit);
			REG_SLOW:  prdata = PDATA_W'(cfg_q.slow_limit);
			default:   prdata = '0;
		endcase
	end

endmodule

/* sv/hrbi_div.sv */
// Restoring divider of the heart-rate averager, one quotient bit per cycle.
// Depends on hrbi_pkg for its operand width.
module hrbi_div import hrbi_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic [DIV_W-1:0] quotient,
	output logic             done,
	output logic             busy
);

	logic              busy_q;
	logic              done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DIV_W-1:0]  dvsr_q;
	logic [DIV_W:0]    shifted;
	logic              fits;

	// One restoring step: shift in the next dividend bit and try a subtract.
	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign fits    = shifted >= {1'b0, dvsr_q};

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CW'(DIV_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= dividend;
			dvsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DIV_W'(shifted - {1'b0, dvsr_q}) : shifted[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;
	assign busy     = busy_q;

endmodule

/* sv/hrbi_datapath.sv */
// Datapath of the heart-rate averager: hysteresis detector, period counter,
// rate ring with running sum, blink classification and output register.
// Depends on hrbi_pkg and instantiates hrbi_div.
module hrbi_datapath import hrbi_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  cmd_t                cmd,
	output status_t             status,
	input  logic [SAMPLE_W-1:0] sample,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [RATE_W-1:0]   average_rate,
	output logic [BLINK_W-1:0]  blink_period,
	output logic                alarm
);

	phase_t             phase_q;
	phase_t             phase_d;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_inc;
	logic               hit_hi;
	logic               hit_lo;
	logic               period_done;

	logic [RATE_W-1:0]  hist_q [HIST_DEPTH];
	logic [HIST_AW-1:0] ptr_q;
	logic [SUM_W-1:0]   sum_q;
	logic [RATE_W-1:0]  rate_c;
	logic [RATE_W-1:0]  avg;
	logic               alarm_hit;
	logic               slow_hit;

	logic               div_start;
	logic [DIV_W-1:0]   div_dividend;
	logic [DIV_W-1:0]   div_divisor;
	logic [DIV_W-1:0]   div_quo;
	logic               div_done;
	logic               div_busy;
	logic [BLINK_W-1:0] blink_c;

	logic [BLINK_W-1:0] blink_q;
	logic               alarm_q;
	logic               out_valid_q;
	logic [RATE_W-1:0]  avg_out_q;
	logic [BLINK_W-1:0] blink_out_q;
	logic               alarm_out_q;

	// Level compares and the saturating period count.
	assign hit_hi    = sample >= cfg.upper_level;
	assign hit_lo    = sample <= cfg.lower_level;
	assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;
	assign period_done = (phase_q == PH_CNT_FALL) && hit_lo;

	// Next detector phase for the sample on the input.
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_WAIT_RISE: if (hit_hi) phase_d = PH_WAIT_FALL;
			PH_WAIT_FALL: if (hit_lo) phase_d = PH_CNT_RISE;
			PH_CNT_RISE:  if (hit_hi) phase_d = PH_CNT_FALL;
			PH_CNT_FALL:  if (hit_lo) phase_d = PH_CNT_RISE;
			default:      phase_d = PH_WAIT_RISE;
		endcase
	end

	// Each accepted item steps the detector and, while counting, the period count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT_RISE;
			count_q <= '0;
		end else if (cmd.accept) begin
			phase_q <= phase_d;
			if (period_done) begin
				count_q <= '0;
			end else if (phase_q == PH_CNT_RISE || phase_q == PH_CNT_FALL) begin
				count_q <= count_inc;
			end
		end
	end

	// Shared divider: rate from the finished period, then, off the fast path, the blink period.
	assign div_start    = cmd.rate_start || cmd.blink_start;
	assign div_dividend = cmd.blink_start ? MS_PER_MINUTE : cfg.rate_numerator;
	assign div_divisor  = cmd.blink_start ? DIV_W'(avg) : count_inc;

	hrbi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quo),
		.done     (div_done),
		.busy     (div_busy)
	);

	// Instant rate saturates at the largest storable value.
	assign rate_c = (div_quo > DIV_W'(RATE_MAX)) ? RATE_MAX : div_quo[RATE_W-1:0];

	// Rate ring and running sum; the oldest entry leaves as the new one enters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
			ptr_q <= '0;
			sum_q <= '0;
		end else if (cmd.hist_update) begin
			hist_q[ptr_q] <= rate_c;
			ptr_q <= (ptr_q == HIST_AW'(HIST_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
			sum_q <= sum_q - SUM_W'(hist_q[ptr_q]) + SUM_W'(rate_c);
		end
	end

	// Average and its classification against the limits.
	assign avg       = RATE_W'(sum_q / HIST_DEPTH);
	assign alarm_hit = avg >= cfg.alarm_limit;
	assign slow_hit  = avg <= cfg.slow_limit;

	// Blink period from the division, kept within the indicator range.
	always_comb begin
		if (div_quo > DIV_W'(BLINK_SLOW)) begin
			blink_c = BLINK_SLOW;
		end else if (div_quo < DIV_W'(BLINK_ALARM)) begin
			blink_c = BLINK_ALARM;
		end else begin
			blink_c = div_quo[BLINK_W-1:0];
		end
	end

	// Result under construction.
	always_ff @(posedge clk) begin
		if (cmd.class_eval) begin
			alarm_q <= alarm_hit;
			blink_q <= alarm_hit ? BLINK_ALARM : BLINK_SLOW;
		end else if (cmd.blink_capture) begin
			blink_q <= blink_c;
		end
	end

	// Output register; it holds a result until the item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			avg_out_q   <= avg;
			blink_out_q <= blink_q;
			alarm_out_q <= alarm_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign average_rate = avg_out_q;
	assign blink_period = blink_out_q;
	assign alarm        = alarm_out_q;

	// Status toward the controller.
	assign status.period_done = period_done;
	assign status.fast_path   = alarm_hit || slow_hit;
	assign status.div_done    = div_done;
	assign status.div_busy    = div_busy;
	assign status.out_free    = !out_valid_q || out_ready;

endmodule

/* sv/hrbi_ctrl.sv */
// Controller of the heart-rate averager: sequences sample intake, the two
// divisions, the ring update and the result hand-off. Depends on hrbi_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hrbi_ctrl import hrbi_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_RATE  = 5'b00010,
		S_CLASS = 5'b00100,
		S_BDIV  = 5'b01000,
		S_EMIT  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid && status.period_done) begin
					cmd.rate_start = 1'b1;
					state_d        = S_RATE;
				end
			end
			S_RATE: begin
				if (status.div_done) begin
					cmd.hist_update = 1'b1;
					state_d         = S_CLASS;
				end
			end
			S_CLASS: begin
				cmd.class_eval = 1'b1;
				if (status.fast_path) begin
					state_d = S_EMIT;
				end else begin
					cmd.blink_start = 1'b1;
					state_d         = S_BDIV;
				end
			end
			S_BDIV: begin
				if (status.div_done) begin
					cmd.blink_capture = 1'b1;
					state_d           = S_EMIT;
				end
			end
			S_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// The divider is started only when it is free.
	`ASSERT_NEVER(a_div_start_busy, (cmd.rate_start || cmd.blink_start) && status.div_busy, "divider started while busy")
	// A result is loaded only when the output register can take it.
	`ASSERT_CLKRST(a_emit_free, cmd.emit |-> status.out_free, "result loaded over a waiting item")
	// A finished period always leads into the rate division.
	`ASSERT_CLKRST(a_rate_follows, cmd.rate_start |=> (state_q == S_RATE && status.div_busy), "rate division did not start")

endmodule

/* verif/tb.sv */
// Self-checking testbench for the heart-rate beat interval averager.
// Depends on hrbi_pkg and the heart_rate_beat_interval_averager top level; predicts
// every beat result in place and compares it with what the block returns.
`timescale 1ns / 100ps

module tb;
	import hrbi_pkg::*;

	localparam int SETTLE_CYCLES = 50;
	localparam int HOLD_CYCLES   = 400;
	localparam int STALL_LIMIT   = 3000;
	localparam int PHASE_ITEMS   = 95;
	localparam int PHASE_BEATS   = 6;

	// One beat result as the block reports it.
	typedef struct packed {
		logic [RATE_W-1:0]  avg;
		logic [BLINK_W-1:0] blink;
		logic               alarm;
	} beat_result_t;

	// One row of the directed script: a sample and, where obvious, its result.
	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		bit                  typed;
		beat_result_t        want;
	} script_row_t;

	localparam beat_result_t NO_BEAT = '0;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [SAMPLE_W-1:0] sample = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [RATE_W-1:0]   average_rate;
	logic [BLINK_W-1:0]  blink_period;
	logic                alarm;

	heart_rate_beat_interval_averager u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.average_rate(average_rate),
		.blink_period(blink_period),
		.alarm(alarm)
	);

	// Predicted block state and register copy.
	cfg_t               reg_cfg;
	phase_t             beat_phase;
	logic [CNT_W-1:0]   beat_count;
	logic [RATE_W-1:0]  rate_ring [HIST_DEPTH];
	logic [HIST_AW-1:0] ring_slot;
	logic [SUM_W-1:0]   ring_sum;

	beat_result_t pending_beats [$];
	int  mismatches = 0;
	int  items_sent = 0;
	int  beats_due = 0;
	bit  steady = 1'b0;
	bit  hold_req = 1'b0;
	bit  pause_pending = 1'b0;

	// Directed script, run right after reset with the default registers.
	script_row_t beat_script [21] = '{
		'{12'd2684, 1'b0, NO_BEAT},                       // one below the upper level
		'{12'd1590, 1'b0, NO_BEAT},                       // a fall while waiting for a rise
		'{12'd2685, 1'b0, NO_BEAT},                       // rise exactly at the level
		'{12'd1591, 1'b0, NO_BEAT},                       // one above the lower level
		'{12'd4095, 1'b0, NO_BEAT},
		'{12'd1590, 1'b0, NO_BEAT},                       // fall exactly at the level
		'{12'd2684, 1'b0, NO_BEAT},
		'{12'd2685, 1'b0, NO_BEAT},
		'{12'd1591, 1'b0, NO_BEAT},
		'{12'd0,    1'b1, '{15'd937, 11'd10, 1'b1}},     // count 4, rate 7500
		'{12'd4095, 1'b0, NO_BEAT},
		'{12'd0,    1'b1, '{15'd2812, 11'd10, 1'b1}},    // count 2, rate 15000
		'{12'd4095, 1'b0, NO_BEAT},
		'{12'd1590, 1'b1, '{15'd4687, 11'd10, 1'b1}},
		'{12'hAAA,  1'b0, NO_BEAT},
		'{12'h555,  1'b1, '{15'd6562, 11'd10, 1'b1}},
		'{12'd2000, 1'b0, NO_BEAT},
		'{12'd2000, 1'b0, NO_BEAT},
		'{12'd3000, 1'b0, NO_BEAT},
		'{12'd2000, 1'b0, NO_BEAT},
		'{12'd1000, 1'b0, NO_BEAT}
	};

	// Clock.
	initial begin
		forever #1 clk = ~clk;
	end

	// Advances the hysteresis detector by one sample; returns 1 when a beat completes.
	function automatic bit predict_beat(input logic [SAMPLE_W-1:0] s, output beat_result_t r);
		logic [31:0] rate;
		logic [31:0] avg;
		logic [31:0] blink;
		r = '0;
		case (beat_phase)
			PH_WAIT_RISE: begin
				if (s >= reg_cfg.upper_level) beat_phase = PH_WAIT_FALL;
				return 1'b0;
			end
			PH_WAIT_FALL: begin
				if (s <= reg_cfg.lower_level) beat_phase = PH_CNT_RISE;
				return 1'b0;
			end
			PH_CNT_RISE: begin
				if (beat_count != COUNT_MAX) beat_count++;
				if (s >= reg_cfg.upper_level) beat_phase = PH_CNT_FALL;
				return 1'b0;
			end
			default: begin
				if (beat_count != COUNT_MAX) beat_count++;
				if (s > reg_cfg.lower_level) return 1'b0;
			end
		endcase

		// A period has ended: instant rate into the ring, then the ring mean.
		beat_phase = PH_CNT_RISE;
		rate = (beat_count != 0) ? 32'(reg_cfg.rate_numerator) / 32'(beat_count) : 32'd0;
		if (rate > 32'(RATE_MAX)) rate = 32'(RATE_MAX);
		ring_sum = ring_sum - rate_ring[ring_slot] + rate[RATE_W-1:0];
		rate_ring[ring_slot] = rate[RATE_W-1:0];
		ring_slot = (ring_slot == HIST_DEPTH - 1) ? '0 : ring_slot + 1'b1;
		avg = 32'(ring_sum) / HIST_DEPTH;
		beat_count = '0;

		// Classify the average into alarm, slow or computed blink period.
		if (avg >= reg_cfg.alarm_limit) begin
			r.alarm = 1'b1;
			blink = 32'(BLINK_ALARM);
		end else if (avg <= reg_cfg.slow_limit) begin
			blink = 32'(BLINK_SLOW);
		end else begin
			blink = 32'(MS_PER_MINUTE) / avg;
			if (blink > 32'(BLINK_SLOW)) blink = 32'(BLINK_SLOW);
			if (blink < 32'(BLINK_ALARM)) blink = 32'(BLINK_ALARM);
		end
		r.avg = avg[RATE_W-1:0];
		r.blink = blink[BLINK_W-1:0];
		return 1'b1;
	endfunction

	// Sample generators for the current levels.
	function automatic logic [SAMPLE_W-1:0] high_level();
		return SAMPLE_W'($urandom_range(reg_cfg.upper_level, 4095));
	endfunction

	function automatic logic [SAMPLE_W-1:0] low_level();
		return SAMPLE_W'($urandom_range(0, reg_cfg.lower_level));
	endfunction

	function automatic logic [SAMPLE_W-1:0] mid_level();
		if (reg_cfg.upper_level > reg_cfg.lower_level + 1)
			return SAMPLE_W'($urandom_range(reg_cfg.lower_level + 1, reg_cfg.upper_level - 1));
		return SAMPLE_W'($urandom_range(0, 4095));
	endfunction

	// Offers one sample item, starting and ending at a falling edge; valid stays high.
	task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit typed = 1'b0,
			input beat_result_t want = '0);
		beat_result_t r;
		while (!steady && $urandom_range(0, 99) < 13) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (predict_beat(s, r)) begin
			pending_beats.push_back(typed ? want : r);
			beats_due++;
		end
		@(negedge clk);
	endtask

	// One random beat: mostly a well-formed period, sometimes noise or a broken one.
	task automatic send_beat();
		int kind;
		int run;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			repeat ($urandom_range(1, 8)) send_sample(SAMPLE_W'($urandom_range(0, 4095)));
		end else if (kind == 1) begin
			// Rises with no fall between them.
			repeat ($urandom_range(1, 4)) begin
				send_sample(high_level());
				send_sample(mid_level());
			end
		end else begin
			run = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100) : $urandom_range(0, 6);
			repeat (run) send_sample(mid_level());
			repeat ($urandom_range(1, 3)) send_sample(high_level());
			repeat ($urandom_range(0, 8)) send_sample(mid_level());
			repeat ($urandom_range(1, 2)) send_sample(low_level());
		end
	endtask

	// Writes one register, with junk above its width at times, and reads it back.
	task automatic program_reg(input reg_idx_t idx, input logic [31:0] value);
		logic [31:0] field_mask;
		logic [31:0] bus_word;
		logic [31:0] readback;
		case (idx)
			REG_UPPER, REG_LOWER: field_mask = (32'd1 << LEVEL_W) - 1;
			REG_NUM:              field_mask = (32'd1 << NUM_W) - 1;
			default:              field_mask = (32'd1 << LIMIT_W) - 1;
		endcase
		bus_word = value & field_mask;
		if ($urandom_range(0, 1) == 1) bus_word = bus_word | ($urandom & ~field_mask);

		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= bus_word;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_UPPER: reg_cfg.upper_level = bus_word[LEVEL_W-1:0];
			REG_LOWER: reg_cfg.lower_level = bus_word[LEVEL_W-1:0];
			REG_NUM:   reg_cfg.rate_numerator = bus_word[NUM_W-1:0];
			REG_ALARM: reg_cfg.alarm_limit = bus_word[LIMIT_W-1:0];
			default:   reg_cfg.slow_limit = bus_word[LIMIT_W-1:0];
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;

		@(negedge clk);
		psel <= 1'b1;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (readback !== (bus_word & field_mask)) begin
			$error("register %s: expected %0d, got %0d", idx.name(), bus_word & field_mask,
				readback);
			mismatches++;
		end
	endtask

	// Receiver: random back-pressure, one long hold-off on request.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			out_ready <= steady || ($urandom_range(0, 99) >= 13);
		end
	end

	// Result checker: each returned item against the oldest prediction.
	always @(posedge clk) begin
		beat_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_beats.size() == 0) begin
				$error("unexpected result item: average_rate %0d, blink_period %0d, alarm %0d",
					average_rate, blink_period, alarm);
				mismatches++;
			end else begin
				want = pending_beats.pop_front();
				if (average_rate !== want.avg) begin
					$error("average_rate: expected %0d, got %0d", want.avg, average_rate);
					mismatches++;
				end
				if (blink_period !== want.blink) begin
					$error("blink_period: expected %0d, got %0d", want.blink, blink_period);
					mismatches++;
				end
				if (alarm !== want.alarm) begin
					$error("alarm: expected %0d, got %0d", want.alarm, alarm);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: ends the run when nothing moves for too long.
	initial begin
		int quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Main sequence: reset, directed script, then register settings with random beats.
	initial begin
		cfg_t plan [7];
		int   first_items;
		int   first_beats;

		reg_cfg = '{UPPER_RST, LOWER_RST, NUM_RST, ALARM_RST, SLOW_RST};
		beat_phase = PH_WAIT_RISE;
		beat_count = '0;
		foreach (rate_ring[i]) rate_ring[i] = '0;
		ring_slot = '0;
		ring_sum = '0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (beat_script[i])
			send_sample(beat_script[i].sample, beat_script[i].typed, beat_script[i].want);

		// Extremes first, then the defaults again, then random settings.
		plan[0] = '{12'd4095, 12'd0, 16'd65535, 15'd30000, 15'd0};
		plan[1] = '{12'd0, 12'd4095, 16'd1, 15'd0, 15'd30000};
		plan[2] = '{UPPER_RST, LOWER_RST, NUM_RST, ALARM_RST, SLOW_RST};
		for (int p = 3; p < 7; p++) begin
			if (p % 2 == 1) begin
				plan[p].upper_level = LEVEL_W'($urandom_range(2000, 4095));
				plan[p].lower_level = LEVEL_W'($urandom_range(0, 2000));
				plan[p].alarm_limit = LIMIT_W'($urandom_range(50, 3000));
				plan[p].slow_limit  = LIMIT_W'($urandom_range(0, plan[p].alarm_limit));
			end else begin
				plan[p].upper_level = LEVEL_W'($urandom_range(0, 4095));
				plan[p].lower_level = LEVEL_W'($urandom_range(0, 4095));
				plan[p].alarm_limit = LIMIT_W'($urandom_range(0, 30000));
				plan[p].slow_limit  = LIMIT_W'($urandom_range(0, 30000));
			end
			plan[p].rate_numerator = NUM_W'($urandom_range(1, 65535));
		end

		for (int p = 0; p < 7; p++) begin
			// Registers change only with the block idle.
			in_valid <= 1'b0;
			while (pending_beats.size() != 0) @(posedge clk);
			repeat (SETTLE_CYCLES) @(negedge clk);
			program_reg(REG_UPPER, 32'(plan[p].upper_level));
			program_reg(REG_LOWER, 32'(plan[p].lower_level));
			program_reg(REG_NUM, 32'(plan[p].rate_numerator));
			program_reg(REG_ALARM, 32'(plan[p].alarm_limit));
			program_reg(REG_SLOW, 32'(plan[p].slow_limit));

			steady = (p == 3);
			pause_pending = (p == 2);
			if (p == 1) hold_req = 1'b1;

			first_items = items_sent;
			first_beats = beats_due;
			while (items_sent - first_items < PHASE_ITEMS || beats_due - first_beats < PHASE_BEATS)
			begin
				// Sender stops until every predicted result has come back.
				if (pause_pending && items_sent - first_items >= PHASE_ITEMS / 2) begin
					in_valid <= 1'b0;
					while (pending_beats.size() != 0) @(posedge clk);
					@(negedge clk);
					pause_pending = 1'b0;
				end
				send_beat();
			end
		end

		steady = 1'b0;
		in_valid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* sim.f */
+incdir+sv
sv/hrbi_pkg.sv
sv/hrbi_regs.sv
sv/hrbi_div.sv
sv/hrbi_datapath.sv
sv/hrbi_ctrl.sv
sv/heart_rate_beat_interval_averager.sv
verif/tb.sv
